@@ hdl/vrt_pkg.sv @@
package vrt_pkg;

   localparam int GRID_X_DEF     = 32;
   localparam int GRID_Y_DEF     = 32;
   localparam int GRID_DEPTH_DEF = 16;

   // walk region, independent of the stored extent
   localparam int WALK_X_MAX = 32;
   localparam int WALK_Y_MAX = 20;
   localparam int WALK_Z_MIN = -10;

   localparam int CELL_W  = 11;
   localparam int ORG_W   = 20;
   localparam int DIST_W  = 19;
   localparam int MAG_W   = 20;
   localparam int NUM0_W  = 13;
   localparam int NSQ_W   = 25;
   localparam int SUM_W   = 40;
   localparam int DM_W    = 38;
   localparam int CROSS_W = 40;
   localparam int Q_W     = 60;
   localparam int P_W     = 80;
   localparam int LIM_W   = 76;
   localparam int MA_W    = 40;
   localparam int MB_W    = 48;
   localparam int CHUNK_W = 24;
   localparam int ACC_W   = 80;
   localparam int FRAC_W  = 12;

   localparam int SETUP_ISSUE = 30;

   localparam logic [NUM0_W-1:0] ONE_Q12 = NUM0_W'(4096);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_RAY   = 1'b1;

   localparam logic [2:0] FACE_NONE  = 3'd0;
   localparam logic [2:0] FACE_NEG_Z = 3'd0;
   localparam logic [2:0] FACE_POS_X = 3'd1;
   localparam logic [2:0] FACE_NEG_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_X = 3'd3;
   localparam logic [2:0] FACE_POS_Y = 3'd4;
   localparam logic [2:0] FACE_POS_Z = 3'd5;

   typedef logic signed [CELL_W-1:0] cell_type;
   typedef logic [1:0] axis_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_READ,
      ST_WR_MOD,
      ST_SETUP,
      ST_WALK_READ,
      ST_WALK_TEST,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      MD_SUM,
      MD_DM,
      MD_NSQ,
      MD_CROSS,
      MD_LIM,
      MD_Q,
      MD_P
   } mdest_type;

   typedef struct packed {
      logic      valid;
      logic      first;
      logic      last;
      logic      hi;
      mdest_type dest;
      axis_type  axis;
      logic      sub;
   } mctl_type;

   // the j-th axis other than a
   function automatic axis_type other_axis(axis_type a, logic j);
      axis_type jj;
      jj = axis_type'(j);
      return (jj < a) ? jj : jj + 2'd1;
   endfunction

   function automatic logic [2:0] face_of(axis_type a, logic neg);
      logic [2:0] f;
      unique case (a)
         2'd0:    f = neg ? FACE_NEG_X : FACE_POS_X;
         2'd1:    f = neg ? FACE_NEG_Y : FACE_POS_Y;
         default: f = neg ? FACE_NEG_Z : FACE_POS_Z;
      endcase
      return f;
   endfunction

endpackage

@@ hdl/voxel_ray_traversal.sv @@
// Voxel ray caster over a one-bit occupancy map held in a single-port memory of
// GRID_Y*GRID_DEPTH rows of GRID_X bits. After reset the map is swept clear, one
// row per cycle, with req_stall high. A write item reads its row and then writes
// the row back, and gives no result. A ray item first runs a setup, in which one
// shared 40x24 multiplier builds the exact crossing products, then for each cell
// tested a map read followed by a test and step, a final map read when the ray
// leaves the walk region, and an emit step that hands the result to the output
// register. The output register lets the next item be taken while a result still
// waits on rsp_stall.
module voxel_ray_traversal #(
   parameter int GRID_X     = vrt_pkg::GRID_X_DEF,
   parameter int GRID_Y     = vrt_pkg::GRID_Y_DEF,
   parameter int GRID_DEPTH = vrt_pkg::GRID_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [4:0]  req_voxel_x,
   input  logic [4:0]  req_voxel_y,
   input  logic [3:0]  req_voxel_depth,
   input  logic        req_voxel_filled,
   input  logic signed [19:0] req_origin_x,
   input  logic signed [19:0] req_origin_y,
   input  logic signed [19:0] req_origin_z,
   input  logic signed [19:0] req_dir_x,
   input  logic signed [19:0] req_dir_y,
   input  logic signed [19:0] req_dir_z,
   input  logic [18:0] req_max_distance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [4:0]  rsp_block_x,
   output logic [4:0]  rsp_block_y,
   output logic signed [4:0] rsp_block_z,
   output logic [2:0]  rsp_face
);

   localparam int XW       = $clog2(GRID_X);
   localparam int ROWS     = GRID_Y * GRID_DEPTH;
   localparam int ROW_W    = $clog2(ROWS);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

   // map memory
   logic [GRID_X-1:0] mem [ROWS];
   logic [GRID_X-1:0] rd_ff;
   logic [GRID_X-1:0] mem_wdata;
   logic [ROW_W-1:0]  mem_addr;
   logic              mem_we;

   // control
   vrt_pkg::state_type state_ff, state_in;
   logic [ROW_W-1:0]   clr_ff;
   logic [4:0]         mstep_ff;
   logic               rsp_valid_ff;
   logic               out_free;

   // write item
   logic [ROW_W-1:0] wrow_ff;
   logic [XW-1:0]    wx_ff;
   logic             wfill_ff;
   logic             wok_ff;

   // ray axes
   logic signed [vrt_pkg::ORG_W-1:0] org_w [3];
   logic signed [vrt_pkg::ORG_W-1:0] dir_w [3];
   vrt_pkg::cell_type              cell_ff  [3];
   logic [vrt_pkg::MAG_W-1:0]      mag_ff   [3];
   logic [vrt_pkg::NUM0_W-1:0]     n0_ff    [3];
   logic                           moving_ff[3];
   logic                           neg_ff   [3];
   logic [vrt_pkg::DIST_W-1:0]     dist_ff;
   logic [vrt_pkg::SUM_W-1:0]      s_ff;
   logic [vrt_pkg::DM_W-1:0]       dm_ff    [3];
   logic [vrt_pkg::NSQ_W-1:0]      nsq_ff   [3];
   logic [vrt_pkg::CROSS_W-1:0]    cross_ff [3][2];
   logic [vrt_pkg::LIM_W-1:0]      lim_ff   [3];
   logic [vrt_pkg::Q_W-1:0]        q_ff     [3];
   logic [vrt_pkg::P_W-1:0]        p_ff     [3];
   logic [2:0]                     face_ff;

   // shared multiplier
   vrt_pkg::mctl_type mctl_ff, mctl_in;
   logic [vrt_pkg::MA_W-1:0]    op_a;
   logic [vrt_pkg::MB_W-1:0]    op_b;
   logic [vrt_pkg::CHUNK_W-1:0] op_chunk;
   logic [vrt_pkg::MA_W+vrt_pkg::CHUNK_W-1:0] prod_ff;
   logic [vrt_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [4:0]                  off;
   vrt_pkg::axis_type           ax;

   // walk
   vrt_pkg::axis_type k_ff, k_sel;
   logic              readable_ff;
   logic [XW-1:0]     xidx_ff;
   logic              outside, readable, hit_now, beyond_now;
   logic              e01, e02, e12;
   vrt_pkg::cell_type negz;
   logic [ROW_W-1:0]  walk_row;

   // result
   logic       res_hit_ff;
   logic [4:0] res_x_ff, res_y_ff, res_z_ff;

   assign org_w[0] = req_origin_x;
   assign org_w[1] = req_origin_y;
   assign org_w[2] = req_origin_z;
   assign dir_w[0] = req_dir_x;
   assign dir_w[1] = req_dir_y;
   assign dir_w[2] = req_dir_z;

   assign req_stall = (state_ff != vrt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // walk decisions
   assign outside = (cell_ff[0] < 0) || (cell_ff[0] > vrt_pkg::WALK_X_MAX) ||
                    (cell_ff[1] < 0) || (cell_ff[1] > vrt_pkg::WALK_Y_MAX) ||
                    (cell_ff[2] < vrt_pkg::WALK_Z_MIN);
   assign negz     = -cell_ff[2];
   assign readable = (cell_ff[2] <= 0) && (cell_ff[0] < GRID_X) && (cell_ff[1] < GRID_Y) &&
                     (negz < GRID_DEPTH);
   assign walk_row = ROW_W'(int'(negz) * GRID_Y + int'(cell_ff[1]));

   assign e01 = moving_ff[0] && (!moving_ff[1] || (cross_ff[0][0] < cross_ff[1][0]));
   assign e02 = moving_ff[0] && (!moving_ff[2] || (cross_ff[0][1] < cross_ff[2][0]));
   assign e12 = moving_ff[1] && (!moving_ff[2] || (cross_ff[1][1] < cross_ff[2][1]));
   assign k_sel = e01 ? (e02 ? 2'd0 : 2'd2) : (e12 ? 2'd1 : 2'd2);

   assign hit_now    = readable_ff && rd_ff[xidx_ff];
   assign beyond_now = !moving_ff[k_ff] ||
                       (p_ff[k_ff] > vrt_pkg::P_W'(lim_ff[k_ff]));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vrt_pkg::ST_CLEAR: begin
            if (clr_ff == ROW_LAST) state_in = vrt_pkg::ST_IDLE;
         end
         vrt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_opcode == vrt_pkg::OP_RAY) ? vrt_pkg::ST_SETUP
                                                          : vrt_pkg::ST_WR_READ;
            end
         end
         vrt_pkg::ST_WR_READ: state_in = vrt_pkg::ST_WR_MOD;
         vrt_pkg::ST_WR_MOD:  state_in = vrt_pkg::ST_IDLE;
         vrt_pkg::ST_SETUP: begin
            if (mstep_ff == 5'(vrt_pkg::SETUP_ISSUE)) state_in = vrt_pkg::ST_WALK_READ;
         end
         vrt_pkg::ST_WALK_READ: begin
            state_in = outside ? vrt_pkg::ST_EMIT : vrt_pkg::ST_WALK_TEST;
         end
         vrt_pkg::ST_WALK_TEST: begin
            state_in = (hit_now || beyond_now) ? vrt_pkg::ST_EMIT : vrt_pkg::ST_WALK_READ;
         end
         vrt_pkg::ST_EMIT: begin
            if (out_free) state_in = vrt_pkg::ST_IDLE;
         end
      endcase
   end

   // memory port
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = rd_ff;
      mem_addr  = wrow_ff;
      unique case (state_ff)
         vrt_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            mem_addr  = clr_ff;
         end
         vrt_pkg::ST_WR_MOD: begin
            mem_we             = wok_ff;
            mem_wdata[wx_ff]   = wfill_ff;
         end
         vrt_pkg::ST_WALK_READ: mem_addr = walk_row;
         default: mem_addr = wrow_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rd_ff <= mem[mem_addr];
   end

   // setup schedule: squares, products and cross terms through one multiplier
   always_comb begin
      mctl_in      = '0;
      mctl_in.dest = vrt_pkg::MD_SUM;
      op_a         = '0;
      op_b         = '0;
      off          = '0;
      ax           = '0;
      if (state_ff == vrt_pkg::ST_SETUP && mstep_ff < 5'(vrt_pkg::SETUP_ISSUE)) begin
         mctl_in.valid = 1'b1;
         mctl_in.first = 1'b1;
         mctl_in.last  = 1'b1;
         priority if (mstep_ff < 5'd3) begin
            ax = 2'(mstep_ff);
            op_a = vrt_pkg::MA_W'(mag_ff[ax]);
            op_b = vrt_pkg::MB_W'(mag_ff[ax]);
            mctl_in.first = (mstep_ff == 5'd0);
            mctl_in.last  = (mstep_ff == 5'd2);
            mctl_in.dest  = vrt_pkg::MD_SUM;
         end else if (mstep_ff < 5'd6) begin
            ax = 2'(mstep_ff - 5'd3);
            op_a = vrt_pkg::MA_W'(dist_ff);
            op_b = vrt_pkg::MB_W'(mag_ff[ax]);
            mctl_in.dest = vrt_pkg::MD_DM;
         end else if (mstep_ff < 5'd9) begin
            ax = 2'(mstep_ff - 5'd6);
            op_a = vrt_pkg::MA_W'(n0_ff[ax]);
            op_b = vrt_pkg::MB_W'(n0_ff[ax]);
            mctl_in.dest = vrt_pkg::MD_NSQ;
         end else if (mstep_ff < 5'd15) begin
            off = mstep_ff - 5'd9;
            ax  = off[2:1];
            op_a = vrt_pkg::MA_W'(mag_ff[vrt_pkg::other_axis(ax, off[0])]);
            op_b = vrt_pkg::MB_W'(n0_ff[ax]);
            mctl_in.sub  = off[0];
            mctl_in.dest = vrt_pkg::MD_CROSS;
         end else if (mstep_ff < 5'd21) begin
            off = mstep_ff - 5'd15;
            ax  = off[2:1];
            op_a = vrt_pkg::MA_W'(dm_ff[ax]);
            op_b = vrt_pkg::MB_W'(dm_ff[ax]);
            mctl_in.hi    = off[0];
            mctl_in.first = !off[0];
            mctl_in.last  = off[0];
            mctl_in.dest  = vrt_pkg::MD_LIM;
         end else if (mstep_ff < 5'd24) begin
            ax = 2'(mstep_ff - 5'd21);
            op_a = s_ff;
            op_b = vrt_pkg::MB_W'(n0_ff[ax]);
            mctl_in.dest = vrt_pkg::MD_Q;
         end else begin
            off = mstep_ff - 5'd24;
            ax  = off[2:1];
            op_a = s_ff;
            op_b = vrt_pkg::MB_W'(nsq_ff[ax]);
            mctl_in.hi    = off[0];
            mctl_in.first = !off[0];
            mctl_in.last  = off[0];
            mctl_in.dest  = vrt_pkg::MD_P;
         end
         mctl_in.axis = ax;
      end
   end

   assign op_chunk = mctl_in.hi ? op_b[vrt_pkg::MB_W-1:vrt_pkg::CHUNK_W]
                                : op_b[vrt_pkg::CHUNK_W-1:0];
   assign acc_in = (mctl_ff.first ? '0 : acc_ff) +
                   (mctl_ff.hi ? vrt_pkg::ACC_W'({prod_ff, {vrt_pkg::CHUNK_W{1'b0}}})
                               : vrt_pkg::ACC_W'(prod_ff));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrt_pkg::ST_CLEAR;
         clr_ff       <= '0;
         mstep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mctl_ff      <= '0;
      end else begin
         state_ff <= state_in;
         mctl_ff  <= mctl_in;
         if (state_ff == vrt_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         mstep_ff <= (state_ff == vrt_pkg::ST_SETUP) ? mstep_ff + 5'd1 : 5'd0;
         if (state_ff == vrt_pkg::ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_chunk;
      if (mctl_ff.valid) acc_ff <= acc_in;

      if (state_ff == vrt_pkg::ST_IDLE && req_valid) begin
         wrow_ff  <= ROW_W'(int'(req_voxel_depth) * GRID_Y + int'(req_voxel_y));
         wx_ff    <= XW'(req_voxel_x);
         wfill_ff <= req_voxel_filled;
         wok_ff   <= (int'(req_voxel_x) < GRID_X) && (int'(req_voxel_y) < GRID_Y) &&
                     (int'(req_voxel_depth) < GRID_DEPTH);
         dist_ff  <= req_max_distance;
         face_ff  <= vrt_pkg::FACE_NONE;
         for (int a = 0; a < 3; a++) begin
            cell_ff[a]   <= vrt_pkg::cell_type'(
                               $signed(org_w[a][vrt_pkg::ORG_W-1:vrt_pkg::FRAC_W]));
            moving_ff[a] <= (dir_w[a] != '0);
            neg_ff[a]    <= dir_w[a][vrt_pkg::ORG_W-1];
            mag_ff[a]    <= dir_w[a][vrt_pkg::ORG_W-1] ? vrt_pkg::MAG_W'(~dir_w[a] + 1'b1)
                                                       : vrt_pkg::MAG_W'(dir_w[a]);
            // distance to the first boundary, in the direction of travel
            n0_ff[a] <= vrt_pkg::ONE_Q12 - vrt_pkg::NUM0_W'(dir_w[a][vrt_pkg::ORG_W-1]
                        ? vrt_pkg::FRAC_W'(~org_w[a] + 1'b1)
                        : org_w[a][vrt_pkg::FRAC_W-1:0]);
         end
      end

      if (mctl_ff.valid && mctl_ff.last) begin
         unique case (mctl_ff.dest)
            vrt_pkg::MD_SUM:   s_ff <= acc_in[vrt_pkg::SUM_W-1:0];
            vrt_pkg::MD_DM:    dm_ff[mctl_ff.axis] <= acc_in[vrt_pkg::DM_W-1:0];
            vrt_pkg::MD_NSQ:   nsq_ff[mctl_ff.axis] <= acc_in[vrt_pkg::NSQ_W-1:0];
            vrt_pkg::MD_CROSS: cross_ff[mctl_ff.axis][mctl_ff.sub] <=
                                  acc_in[vrt_pkg::CROSS_W-1:0];
            vrt_pkg::MD_LIM:   lim_ff[mctl_ff.axis] <= acc_in[vrt_pkg::LIM_W-1:0];
            vrt_pkg::MD_Q:     q_ff[mctl_ff.axis] <= acc_in[vrt_pkg::Q_W-1:0];
            vrt_pkg::MD_P:     p_ff[mctl_ff.axis] <= acc_in[vrt_pkg::P_W-1:0];
            default:           s_ff <= s_ff;
         endcase
      end

      if (state_ff == vrt_pkg::ST_WALK_READ) begin
         k_ff        <= k_sel;
         readable_ff <= readable;
         xidx_ff     <= XW'(cell_ff[0]);
         if (outside) res_hit_ff <= 1'b0;
      end

      if (state_ff == vrt_pkg::ST_WALK_TEST) begin
         if (hit_now) begin
            res_hit_ff <= 1'b1;
            res_x_ff   <= cell_ff[0][4:0];
            res_y_ff   <= cell_ff[1][4:0];
            res_z_ff   <= cell_ff[2][4:0];
         end else if (beyond_now) begin
            res_hit_ff <= 1'b0;
         end else begin
            // step across the nearest boundary, crossing products advance by adds
            cell_ff[k_ff] <= neg_ff[k_ff] ? cell_ff[k_ff] - 1'b1 : cell_ff[k_ff] + 1'b1;
            face_ff       <= vrt_pkg::face_of(k_ff, neg_ff[k_ff]);
            for (int j = 0; j < 2; j++) begin
               cross_ff[k_ff][j] <= cross_ff[k_ff][j] + vrt_pkg::CROSS_W'(
                  {mag_ff[vrt_pkg::other_axis(k_ff, 1'(j))], {vrt_pkg::FRAC_W{1'b0}}});
            end
            q_ff[k_ff] <= q_ff[k_ff] + vrt_pkg::Q_W'({s_ff, {vrt_pkg::FRAC_W{1'b0}}});
            p_ff[k_ff] <= p_ff[k_ff] + vrt_pkg::P_W'({q_ff[k_ff], 13'b0}) +
                          vrt_pkg::P_W'({s_ff, 24'b0});
         end
      end

      if (state_ff == vrt_pkg::ST_EMIT && out_free) begin
         rsp_hit     <= res_hit_ff;
         rsp_block_x <= res_hit_ff ? res_x_ff : 5'd0;
         rsp_block_y <= res_hit_ff ? res_y_ff : 5'd0;
         rsp_block_z <= res_hit_ff ? res_z_ff : 5'd0;
         rsp_face    <= face_ff;
      end
   end

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == vrt_pkg::ST_EMIT))
      else $error("result raised outside emit");

   a_mul_in_setup: assert property (@(posedge clock) disable iff (reset)
      mctl_ff.valid |-> $past(state_ff == vrt_pkg::ST_SETUP))
      else $error("multiplier busy outside setup");

   a_mem_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == vrt_pkg::ST_CLEAR || state_ff == vrt_pkg::ST_WR_MOD))
      else $error("map written during a ray");

   a_hit_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_block_z <= 0))
      else $error("hit reported above depth zero");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

   typedef struct {
      logic               opcode;
      logic [4:0]         vx;
      logic [4:0]         vy;
      logic [3:0]         vdepth;
      logic               filled;
      logic signed [19:0] org [3];
      logic signed [19:0] dir [3];
      logic [18:0]        max_dist;
   } ray_req_type;

   typedef struct {
      logic              hit;
      logic [4:0]        bx;
      logic [4:0]        by;
      logic signed [4:0] bz;
      logic [2:0]        face;
   } cast_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_opcode;
   logic [4:0] req_voxel_x;
   logic [4:0] req_voxel_y;
   logic [3:0] req_voxel_depth;
   logic req_voxel_filled;
   logic signed [19:0] req_origin_x;
   logic signed [19:0] req_origin_y;
   logic signed [19:0] req_origin_z;
   logic signed [19:0] req_dir_x;
   logic signed [19:0] req_dir_y;
   logic signed [19:0] req_dir_z;
   logic [18:0] req_max_distance;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_hit;
   logic [4:0] rsp_block_x;
   logic [4:0] rsp_block_y;
   logic signed [4:0] rsp_block_z;
   logic [2:0] rsp_face;

   bit occupied [32][32][16];
   cast_type pending_casts [$];
   int mismatches;
   int send_idle_pct;
   int recv_idle_pct;
   int recv_hold;

   voxel_ray_traversal i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_voxel_x(req_voxel_x),
      .req_voxel_y(req_voxel_y),
      .req_voxel_depth(req_voxel_depth),
      .req_voxel_filled(req_voxel_filled),
      .req_origin_x(req_origin_x),
      .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z),
      .req_dir_x(req_dir_x),
      .req_dir_y(req_dir_y),
      .req_dir_z(req_dir_z),
      .req_max_distance(req_max_distance),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .rsp_block_x(rsp_block_x),
      .rsp_block_y(rsp_block_y),
      .rsp_block_z(rsp_block_z),
      .rsp_face(rsp_face)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("voxel_ray_traversal test failed");
      $finish;
   end

   // a crosses its next boundary strictly before b
   function automatic bit crosses_first(bit ma, longint unsigned na, longint unsigned ga,
                                        bit mb, longint unsigned nb, longint unsigned gb);
      if (!ma) return 1'b0;
      if (!mb) return 1'b1;
      return na * gb < nb * ga;
   endfunction

   function automatic cast_type trace_ray(ray_req_type r);
      longint          pos [3];
      int              stp [3];
      bit              mov [3];
      longint unsigned num [3];
      longint unsigned mag [3];
      longint unsigned sumsq;
      logic [19:0]     neg;
      logic [127:0]    lhs;
      logic [127:0]    rhs;
      cast_type        res;
      int              k;
      res = '{hit: 1'b0, bx: '0, by: '0, bz: '0, face: vrt_pkg::FACE_NONE};
      for (int a = 0; a < 3; a++) begin
         pos[a] = longint'(r.org[a]) >>> 12;
         mov[a] = r.dir[a] != 0;
         stp[a] = r.dir[a] > 0 ? 1 : (r.dir[a] < 0 ? -1 : 0);
         mag[a] = r.dir[a] < 0 ? longint'(-longint'(r.dir[a])) : longint'(r.dir[a]);
         neg = -r.org[a];
         num[a] = r.dir[a] >= 0 ? 4096 - r.org[a][11:0] : 4096 - neg[11:0];
      end
      sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      forever begin
         if (pos[0] < 0 || pos[0] > vrt_pkg::WALK_X_MAX || pos[1] < 0
             || pos[1] > vrt_pkg::WALK_Y_MAX || pos[2] < vrt_pkg::WALK_Z_MIN)
            return res;
         if (pos[2] <= 0 && pos[0] < 32 && pos[1] < 32 && -pos[2] < 16
             && occupied[pos[0]][pos[1]][-pos[2]]) begin
            res.hit = 1'b1;
            res.bx = pos[0][4:0];
            res.by = pos[1][4:0];
            res.bz = pos[2][4:0];
            return res;
         end
         // ties favor y over x and z over both
         if (crosses_first(mov[0], num[0], mag[0], mov[1], num[1], mag[1]))
            k = crosses_first(mov[0], num[0], mag[0], mov[2], num[2], mag[2]) ? 0 : 2;
         else
            k = crosses_first(mov[1], num[1], mag[1], mov[2], num[2], mag[2]) ? 1 : 2;
         if (!mov[k]) return res;
         lhs = 128'(num[k] * num[k]) * 128'(sumsq);
         rhs = 128'(longint'(r.max_dist) * longint'(r.max_dist)) * 128'(mag[k] * mag[k]);
         if (lhs > rhs) return res;
         pos[k] += stp[k];
         num[k] += 4096;
         case (k)
            0:       res.face = stp[k] < 0 ? vrt_pkg::FACE_NEG_X : vrt_pkg::FACE_POS_X;
            1:       res.face = stp[k] < 0 ? vrt_pkg::FACE_NEG_Y : vrt_pkg::FACE_POS_Y;
            default: res.face = stp[k] < 0 ? vrt_pkg::FACE_NEG_Z : vrt_pkg::FACE_POS_Z;
         endcase
      end
   endfunction

   task automatic send_item(ray_req_type r);
      int gap;
      gap = 0;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
         gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_voxel_x <= r.vx;
      req_voxel_y <= r.vy;
      req_voxel_depth <= r.vdepth;
      req_voxel_filled <= r.filled;
      req_origin_x <= r.org[0];
      req_origin_y <= r.org[1];
      req_origin_z <= r.org[2];
      req_dir_x <= r.dir[0];
      req_dir_y <= r.dir[1];
      req_dir_z <= r.dir[2];
      req_max_distance <= r.max_dist;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (r.opcode == vrt_pkg::OP_WRITE)
         occupied[r.vx][r.vy][r.vdepth] = r.filled;
      else
         pending_casts.push_back(trace_ray(r));
   endtask

   function automatic ray_req_type voxel_write(int x, int y, int dep, bit f);
      ray_req_type r;
      r.opcode = vrt_pkg::OP_WRITE;
      r.vx = 5'(x);
      r.vy = 5'(y);
      r.vdepth = 4'(dep);
      r.filled = f;
      for (int a = 0; a < 3; a++) begin
         r.org[a] = 20'($urandom);
         r.dir[a] = 20'($urandom);
      end
      r.max_dist = 19'($urandom);
      return r;
   endfunction

   function automatic ray_req_type ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                       int max_dist);
      ray_req_type r;
      r = voxel_write($urandom, $urandom, $urandom, 1'($urandom));
      r.opcode = vrt_pkg::OP_RAY;
      r.org = '{20'(ox), 20'(oy), 20'(oz)};
      r.dir = '{20'(dx), 20'(dy), 20'(dz)};
      r.max_dist = 19'(max_dist);
      return r;
   endfunction

   function automatic int random_dir();
      case ($urandom_range(9))
         0, 1:    return 0;
         2:       return $signed(20'($urandom));
         default: return $urandom_range(1, 8192) * ($urandom_range(1) ? 1 : -1);
      endcase
   endfunction

   function automatic ray_req_type random_ray();
      ray_req_type r;
      r = ray($urandom_range(0, 33 * 4096 - 1), $urandom_range(0, 21 * 4096 - 1),
              -$urandom_range(0, 11 * 4096) + 8192, random_dir(), random_dir(), random_dir(),
              $urandom_range(0, 40 * 4096));
      // occasional wild origins and distances
      if ($urandom_range(9) == 0) r.org[$urandom_range(2)] = 20'($urandom);
      if ($urandom_range(9) == 0) r.max_dist = 19'($urandom);
      return r;
   endfunction

   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_casts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with none expected at %0t", $realtime);
         end else begin
            cast_type want;
            want = pending_casts.pop_front();
            if (rsp_hit !== want.hit || rsp_block_x !== want.bx || rsp_block_y !== want.by
                || rsp_block_z !== want.bz || rsp_face !== want.face) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected hit %0d x %0d y %0d z %0d face %0d,",
                           want.hit, want.bx, want.by, want.bz, want.face,
                           " got %0d %0d %0d %0d %0d",
                           rsp_hit, rsp_block_x, rsp_block_y, rsp_block_z, rsp_face);
            end
         end
      end
      if (recv_hold > 0) begin
         rsp_stall <= 1'b1;
         recv_hold--;
      end else
         rsp_stall <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
   end

   task automatic test_directed();
      send_item(voxel_write(0, 0, 0, 1));
      send_item(voxel_write(31, 31, 15, 1));
      send_item(voxel_write(5, 3, 2, 1));
      // origin cell occupied, no boundary crossed
      send_item(ray(0, 0, 0, 4096, 0, 0, 524287));
      // all direction components zero
      send_item(ray(4096 * 7, 4096 * 7, -4096, 0, 0, 0, 524287));
      send_item(ray(4096 * 7 + 100, 4096 * 3 + 50, -4096 * 2 + 10, -4096, 0, 0, 524287));
      send_item(ray(100, 4096 * 3 + 50, -4096 * 2 + 10, 4096, 0, 0, 524287));
      send_item(ray(4096 * 5 + 9, 4096 * 10, -4096 * 2 + 10, 0, -4096, 0, 524287));
      send_item(ray(4096 * 5 + 9, 100, -4096 * 2 + 10, 0, 4096, 0, 524287));
      send_item(ray(4096 * 5 + 9, 4096 * 3 + 9, 4096 * 4, 0, 0, -4096, 524287));
      send_item(ray(4096 * 5 + 9, 4096 * 3 + 9, -4096 * 9, 0, 0, 4096, 524287));
      // exact ties between axes
      send_item(ray(2048, 2048, -2048, 4096, 4096, -4096, 524287));
      // distance zero, and a ray out of range
      send_item(ray(4096 * 4, 4096 * 3, -4096, 4096, 0, 0, 0));
      send_item(ray(4096 * 20, 4096 * 20, -4096, 4096, 0, 0, 4096 * 2));
      // cell inside the walk region but outside the stored extent of x
      send_item(ray(4096 * 32 + 5, 4096 * 4, -4096, 0, 0, 1, 524287));
      send_item(ray(-524288, -524288, -524288, -524288, -524288, -524288, 524287));
      send_item(ray(524287, 524287, 524287, 524287, 524287, 524287, 524287));
      send_item(ray(4096 * 31 + 4095, 4096 * 20, 524287, 0, 0, -524288, 524287));
      send_item(voxel_write(0, 0, 0, 0));
      send_item(voxel_write(31, 31, 15, 0));
      send_item(ray(0, 0, 0, 4096, 0, 0, 524287));
   endtask

   task automatic test_random(int n, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 45)
            send_item(voxel_write($urandom_range(0, 31), $urandom_range(0, 21),
                                  $urandom_range(0, 11), $urandom_range(99) < 75));
         else if ($urandom_range(19) == 0)
            send_item(voxel_write($urandom, $urandom, $urandom, 1'($urandom)));
         else
            send_item(random_ray());
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 600;
      for (int i = 0; i < 25; i++) send_item(random_ray());
      // let everything drain before going on
      req_valid <= 1'b0;
      wait (pending_casts.size() == 0);
      @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= vrt_pkg::OP_WRITE;
      req_voxel_x <= '0;
      req_voxel_y <= '0;
      req_voxel_depth <= '0;
      req_voxel_filled <= 1'b0;
      req_origin_x <= '0;
      req_origin_y <= '0;
      req_origin_z <= '0;
      req_dir_x <= '0;
      req_dir_y <= '0;
      req_dir_z <= '0;
      req_max_distance <= '0;
      rsp_stall <= 1'b0;
      mismatches = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400, 29, 75);
      test_backpressure();
      test_random(400, 75, 29);
      test_random(400, 0, 0);
      req_valid <= 1'b0;
      wait (pending_casts.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("voxel_ray_traversal test passed");
      else
         $display("voxel_ray_traversal test failed");
      $finish;
   end

endmodule
